@@ sv/skts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_pkg
// Shared widths, defaults and item codes for the sorted key table search.
// ----------------------------------------------------------------------------
package skts_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned ENTRY_COUNT_W = 11;
  localparam int unsigned INDEX_W       = 10;
  localparam int unsigned KEY_W         = 64;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned STEPS_W       = 4;

  // Default table shape.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF    = 64;
  localparam int unsigned DATA_BITS_DEF   = 64;

  // Item mode codes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Entry count after reset.
  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RST = ENTRY_COUNT_W'(1);

endpackage

@@ sv/skts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module skts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sorted_key_table_search.sv @@
`timescale 1ns / 1ps
// A load item's result is registered and shows in the cycle after it is accepted.
// A search probes one entry per cycle through the RAM read port, at most
// log2(TABLE_DEPTH)+1 probes, and holds its result in the search state while
// the output is stalled; no new item is taken until the search is done.
// Reset clears the sequencer and output valid, sets entry_count to 1, and leaves the table.
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Table of sorted key/data entries with a halving binary search over the
// first entry_count entries, one probe per cycle into a shared RAM.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
  parameter int unsigned TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = skts_pkg::KEY_BITS_DEF,
  parameter int unsigned DATA_BITS   = skts_pkg::DATA_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_we,
  input  logic [skts_pkg::ENTRY_COUNT_W-1:0] cfg_entry_count,
  // Item input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [skts_pkg::INDEX_W-1:0]       in_entry_index,
  input  logic [skts_pkg::KEY_W-1:0]         in_entry_key,
  input  logic [skts_pkg::DATA_W-1:0]        in_entry_data,
  // Result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [skts_pkg::DATA_W-1:0]        out_match_data,
  output logic [skts_pkg::STEPS_W-1:0]       out_halving_steps
);

  import skts_pkg::*;

  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WORD_W = KEY_BITS + DATA_BITS;

  // Sequencer states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;

  logic                     state_r, state_nxt;
  logic [ENTRY_COUNT_W-1:0] entry_count_r;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [CNT_W-1:0]         probe_r, probe_nxt;
  logic [STEPS_W-1:0]       steps_r, steps_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_found_r, out_found_nxt;
  logic [DATA_W-1:0]        out_data_r, out_data_nxt;
  logic [STEPS_W-1:0]       out_steps_r, out_steps_nxt;

  logic                     in_accept;
  logic                     slot_free;
  logic [31:0]              count_ext;
  logic [31:0]              index_ext;
  logic [CNT_W-1:0]         count_clamped;
  logic                     ram_we;
  logic [WORD_W-1:0]        ram_wdata;
  logic [WORD_W-1:0]        ram_rdata;
  logic [KEY_BITS-1:0]      rd_key;
  logic [DATA_BITS-1:0]     rd_data;
  logic                     key_equal;
  logic                     key_less;
  logic [CNT_W-1:0]         lo_new, hi_new;
  logic [CNT_W-1:0]         next_probe;
  logic                     done;

  // Handshake: the output register frees when empty or being taken.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || ((in_mode == MODE_LOAD) && !slot_free);
  assign in_accept = in_valid && !in_stall;

  // Clamp the configured count into 1 .. TABLE_DEPTH.
  assign count_ext = 32'(entry_count_r);
  always_comb begin
    priority if (count_ext == 32'd0) begin
      count_clamped = CNT_W'(1);
    end else if (count_ext > 32'(TABLE_DEPTH)) begin
      count_clamped = CNT_W'(TABLE_DEPTH);
    end else begin
      count_clamped = CNT_W'(count_ext);
    end
  end

  // Table writes from load items; indexes past the table are dropped.
  assign index_ext = 32'(in_entry_index);
  assign ram_we    = in_accept && (in_mode == MODE_LOAD) && (index_ext < 32'(TABLE_DEPTH));
  assign ram_wdata = {in_entry_key[KEY_BITS-1:0], in_entry_data[DATA_BITS-1:0]};

  skts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (index_ext[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (probe_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key  = ram_rdata[WORD_W-1:DATA_BITS];
  assign rd_data = ram_rdata[DATA_BITS-1:0];

  // Shared compare and halving step for the current probe.
  assign key_equal  = (key_r == rd_key);
  assign key_less   = (key_r < rd_key);
  assign lo_new     = key_less ? lo_r : probe_r;
  assign hi_new     = key_less ? probe_r : hi_r;
  assign next_probe = lo_new + ((hi_new - lo_new) >> 1);
  assign done       = key_equal || (next_probe == probe_r);

  // Sequencer and result register.
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    probe_nxt     = probe_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_data_nxt  = out_data_r;
    out_steps_nxt = out_steps_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_mode == MODE_SEARCH) begin
            state_nxt = ST_SRCH;
            key_nxt   = in_entry_key[KEY_BITS-1:0];
            lo_nxt    = '0;
            hi_nxt    = count_clamped;
            probe_nxt = count_clamped >> 1;
            steps_nxt = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_data_nxt  = '0;
            out_steps_nxt = '0;
          end
        end
      end
      ST_SRCH: begin
        if (done) begin
          // Hold the probe so the read data stays put until the slot frees.
          if (slot_free) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_found_nxt = key_equal;
            out_data_nxt  = key_equal ? DATA_W'(rd_data) : '0;
            out_steps_nxt = steps_r;
          end
        end else begin
          lo_nxt    = lo_new;
          hi_nxt    = hi_new;
          probe_nxt = next_probe;
          steps_nxt = steps_r + STEPS_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= ENTRY_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_entry_count;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    probe_r     <= probe_nxt;
    steps_r     <= steps_nxt;
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
    out_steps_r <= out_steps_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_data    = out_data_r;
  assign out_halving_steps = out_steps_r;

  // The probe always lies inside the live search window.
  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> ((lo_r <= probe_r) && (probe_r < hi_r)))
    else $error("probe outside search window");

  // The table is written only between searches.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("table written during a search");

  // A miss never carries data.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_data_r == '0))
    else $error("miss result with nonzero data");

  // A search that ends leaves the sequencer idle with a result pending.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SRCH) && done && slot_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished search lost its result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_table_search. A short table of directed
// items exercises the edges of the key and data fields, count clamping and an
// unsorted table. Randomized phases follow. Each phase sets the entry count
// while the block is idle, loads a sorted table when asked and then searches for hits,
// near misses and random keys, with a few stray loads mixed in. Every result is
// compared field by field against an in-order prediction.
// ----------------------------------------------------------------------------
module tb;

  import skts_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TBL_DEPTH      = TABLE_DEPTH_DEF;
  localparam int unsigned ITEM_TARGET    = 1750;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam longint      TIMEOUT_CYCLES = 800_000;
  localparam logic [KEY_W-1:0] ALL_ONES  = '1;

  typedef struct packed {
    logic                found;
    logic [DATA_W-1:0]   data;
    logic [STEPS_W-1:0]  steps;
  } lookup_res_t;

  typedef struct {
    logic [ENTRY_COUNT_W-1:0] count;
    logic                     mode;
    logic [INDEX_W-1:0]       idx;
    logic [KEY_W-1:0]         key;
    logic [DATA_W-1:0]        data;
    bit                       typed;
    lookup_res_t              res;
  } stim_row_t;

  localparam lookup_res_t NO_MATCH = '{1'b0, 64'd0, 4'd0};
  localparam int unsigned NUM_ROWS = 21;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [ENTRY_COUNT_W-1:0]  cfg_entry_count;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_mode;
  logic [INDEX_W-1:0]        in_entry_index;
  logic [KEY_W-1:0]          in_entry_key;
  logic [DATA_W-1:0]         in_entry_data;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_found;
  logic [DATA_W-1:0]         out_match_data;
  logic [STEPS_W-1:0]        out_halving_steps;

  // Mirror of the table and the count register, updated as items are accepted.
  logic [KEY_W-1:0]          key_mirror  [TBL_DEPTH];
  logic [DATA_W-1:0]         data_mirror [TBL_DEPTH];
  logic [ENTRY_COUNT_W-1:0]  count_mirror;

  lookup_res_t               pending_results [$];
  stim_row_t                 directed_rows [NUM_ROWS];

  int unsigned err_count;
  int unsigned items_sent;
  int unsigned loads_sent;
  int unsigned searches_sent;
  int unsigned hits_seen;
  int unsigned count_writes;
  int unsigned burst_left;
  bit          hold_request;

  sorted_key_table_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_entry_count   (cfg_entry_count),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_entry_index    (in_entry_index),
    .in_entry_key      (in_entry_key),
    .in_entry_data     (in_entry_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_data    (out_match_data),
    .out_halving_steps (out_halving_steps)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[sorted_key_table_search] ERROR");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Number of entries the search actually covers for a given count.
  function automatic int unsigned searched_span(input logic [ENTRY_COUNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > TBL_DEPTH) return TBL_DEPTH;
    return 32'(cnt);
  endfunction

  // Halving search over the mirrored table.
  function automatic lookup_res_t predict_lookup(input logic [KEY_W-1:0] key);
    lookup_res_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned probe;
    int unsigned nxt;
    int unsigned steps;
    int unsigned guard;
    bit          done;
    r     = NO_MATCH;
    lo    = 0;
    hi    = searched_span(count_mirror);
    probe = hi / 2;
    steps = 0;
    guard = 0;
    done  = 1'b0;
    while (!done && guard < 80) begin
      guard++;
      if (probe >= TBL_DEPTH) begin
        done = 1'b1;
      end else if (key == key_mirror[probe]) begin
        r.found = 1'b1;
        r.data  = data_mirror[probe];
        done    = 1'b1;
      end else begin
        if (key < key_mirror[probe]) hi = probe;
        else lo = probe;
        nxt = lo + (hi - lo) / 2;
        if (nxt == probe) begin
          done = 1'b1;
        end else begin
          probe = nxt;
          steps++;
        end
      end
    end
    r.steps = steps[STEPS_W-1:0];
    return r;
  endfunction

  // Offer one item in bursts with random gaps, then record its expected result.
  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [DATA_W-1:0] data,
                           input bit typed, input lookup_res_t typed_res);
    lookup_res_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    in_entry_key   <= key;
    in_entry_data  <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (mode == MODE_LOAD) begin
      key_mirror[idx]  = key;
      data_mirror[idx] = data;
      r = NO_MATCH;
      loads_sent++;
    end else begin
      r = predict_lookup(key);
      searches_sent++;
    end
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // Write the count only once every outstanding result has come back.
  task automatic set_count(input logic [ENTRY_COUNT_W-1:0] cnt);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_entry_count <= cnt;
    @(posedge clk);
    cfg_we       <= 1'b0;
    count_mirror  = cnt;
    count_writes++;
  endtask

  // Load entries 0..n-1 with non-decreasing keys spread over the whole key range.
  task automatic load_sorted(input int unsigned n);
    logic [KEY_W-1:0] cur;
    logic [KEY_W-1:0] span;
    logic [KEY_W-1:0] step;
    cur = '0;
    for (int unsigned i = 0; i < n; i++) begin
      span = (ALL_ONES - cur) / (n - i + 1);
      step = (span == 0) ? '0 : rand64() % (span + 1);
      if (i > 0 && $urandom_range(31) == 0) step = '0;
      cur = cur + step;
      send_item(MODE_LOAD, INDEX_W'(i), cur, rand64(), 1'b0, NO_MATCH);
    end
  endtask

  // One phase: set the count, optionally reload, then search with some noise.
  task automatic run_phase(input logic [ENTRY_COUNT_W-1:0] cnt, input bit reload,
                           input int unsigned n_search, input bit squeeze);
    int unsigned      n;
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    set_count(cnt);
    n = searched_span(cnt);
    if (reload) load_sorted(n);
    for (int unsigned i = 0; i < n_search; i++) begin
      if (squeeze && i == n_search / 4) hold_request = 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Stray load anywhere in the table; it may break the sort order.
        send_item(MODE_LOAD, INDEX_W'($urandom_range(TBL_DEPTH - 1)), rand64(), rand64(),
                  1'b0, NO_MATCH);
      end else begin
        if (pick < 58) begin
          key = key_mirror[$urandom_range(n - 1)];
        end else if (pick < 78) begin
          key = key_mirror[$urandom_range(n - 1)];
          key = $urandom_range(1) ? key + 1 : key - 1;
        end else if (pick < 90) begin
          key = rand64();
        end else begin
          key = $urandom_range(1) ? ALL_ONES : '0;
        end
        send_item(MODE_SEARCH, INDEX_W'($urandom), key, rand64(), 1'b0, NO_MATCH);
      end
    end
  endtask

  function automatic logic [ENTRY_COUNT_W-1:0] pick_small_count();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return ENTRY_COUNT_W'(1);
    if (r <= 6) return ENTRY_COUNT_W'($urandom_range(2, 32));
    if (r <= 8) return ENTRY_COUNT_W'($urandom_range(33, 160));
    return ENTRY_COUNT_W'($urandom_range(161, 300));
  endfunction

  // Result side: random stall patterns, plus one long hold on request.
  initial begin
    int unsigned seg_len;
    int unsigned pattern;
    int unsigned phase_cnt;
    logic        stall_now;
    out_stall <= 1'b0;
    phase_cnt = 0;
    forever begin
      seg_len = $urandom_range(10, 80);
      pattern = $urandom_range(3);
      repeat (seg_len) begin
        if (hold_request) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        unique case (pattern)
          0: begin
            stall_now = 1'b0;
          end
          1: begin
            stall_now = ($urandom_range(9) < 3);
          end
          2: begin
            stall_now = ($urandom_range(9) < 7);
          end
          default: begin
            stall_now = (phase_cnt % 4 == 0);
          end
        endcase
        phase_cnt++;
        out_stall <= stall_now;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    lookup_res_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%b data=%h steps=%0d", $time,
                 out_found, out_match_data, out_halving_steps);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_found !== exp_r.found) begin
          $display("%0t: found mismatch, expected %b, actual %b", $time,
                   exp_r.found, out_found);
          err_count++;
        end
        if (out_match_data !== exp_r.data) begin
          $display("%0t: match_data mismatch, expected %h, actual %h", $time,
                   exp_r.data, out_match_data);
          err_count++;
        end
        if (out_halving_steps !== exp_r.steps) begin
          $display("%0t: halving_steps mismatch, expected %0d, actual %0d", $time,
                   exp_r.steps, out_halving_steps);
          err_count++;
        end
        if (exp_r.found) hits_seen++;
      end
    end
  end

  // Directed items: field extremes, clamped count, final entry and an unsorted table.
  initial begin
    directed_rows = '{
      '{11'd1, MODE_LOAD,   10'd0,    64'd0,    ALL_ONES, 1'b1, NO_MATCH},
      '{11'd1, MODE_SEARCH, 10'd0,    64'd0,    64'd0,    1'b1, '{1'b1, ALL_ONES, 4'd0}},
      '{11'd1, MODE_SEARCH, 10'd0,    64'd1,    64'd0,    1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'd0,    ALL_ONES, 64'd0,    1'b1, NO_MATCH},
      '{11'd1, MODE_SEARCH, 10'd1023, ALL_ONES, ALL_ONES, 1'b1, '{1'b1, 64'd0, 4'd0}},
      '{11'd1, MODE_SEARCH, 10'd0,    64'd0,    64'd0,    1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'd1023, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'h2AA,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'd0,    64'd10,   64'd100,  1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'd1,    64'd20,   64'd200,  1'b1, NO_MATCH},
      '{11'd1, MODE_LOAD,   10'd2,    64'd30,   64'd300,  1'b1, NO_MATCH},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd20,   64'd0,    1'b1, '{1'b1, 64'd200, 4'd0}},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd10,   64'd0,    1'b0, NO_MATCH},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd30,   64'd0,    1'b0, NO_MATCH},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd5,    64'd0,    1'b0, NO_MATCH},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd35,   64'd0,    1'b0, NO_MATCH},
      '{11'd3, MODE_SEARCH, 10'd0,    64'd25,   64'd0,    1'b0, NO_MATCH},
      '{11'd0, MODE_SEARCH, 10'd0,    64'd10,   64'd0,    1'b1, '{1'b1, 64'd100, 4'd0}},
      '{11'd2, MODE_LOAD,   10'd1,    64'd5,    64'd55,   1'b1, NO_MATCH},
      '{11'd2, MODE_SEARCH, 10'd0,    64'd5,    64'd0,    1'b0, NO_MATCH},
      '{11'd2, MODE_SEARCH, 10'd0,    64'd10,   64'd0,    1'b0, NO_MATCH}
    };
  end

  // Main sequence: reset, directed items, then randomized phases.
  initial begin
    err_count     = 0;
    items_sent    = 0;
    loads_sent    = 0;
    searches_sent = 0;
    hits_seen     = 0;
    count_writes  = 0;
    burst_left    = 0;
    hold_request  = 1'b0;
    count_mirror  = ENTRY_COUNT_RST;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_entry_count <= '0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_LOAD;
    in_entry_index  <= '0;
    in_entry_key    <= '0;
    in_entry_data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].count != count_mirror) set_count(directed_rows[i].count);
      send_item(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].key,
                directed_rows[i].data, directed_rows[i].typed, directed_rows[i].res);
    end

    // Small tables first, then the full table with a long result-side hold.
    run_phase(11'($urandom_range(2, 16)), 1'b1, 30, 1'b0);
    run_phase(11'($urandom_range(2, 16)), 1'b1, 30, 1'b0);
    run_phase(11'(TBL_DEPTH), 1'b1, 150, 1'b1);
    // The whole table is written now, so oversized and zero counts are safe.
    run_phase(11'h7FF, 1'b0, 60, 1'b0);
    run_phase(11'd0, 1'b0, 20, 1'b0);
    while (items_sent < ITEM_TARGET) begin
      run_phase(pick_small_count(), 1'b1, $urandom_range(15, 50), 1'b0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d loads and %0d searches, %0d of them found.",
             items_sent, loads_sent, searches_sent, hits_seen);
    $display("Entry count was written %0d times, including 0, 1024 and 2047.",
             count_writes);
    if (err_count == 0) begin
      $display("[sorted_key_table_search] OK");
    end else begin
      $display("[sorted_key_table_search] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/skts_pkg.sv
sv/skts_ram.sv
sv/sorted_key_table_search.sv
tb/tb.sv
